@@ rtl/bat_pkg.sv @@
// shared types and constants for the bcd alarm table and time formatter
package bat_pkg;

    localparam int HOUR_W = 6;
    localparam int MIN_W  = 7;
    localparam int FUNC_W = 2;
    localparam int SLOT_W = 2;
    localparam int MASK_W = 4;

    // operation codes carried in tuser
    localparam logic [FUNC_W-1:0] FUNC_OBSERVE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALARM   = 2'd1;

    // bcd limits
    localparam logic [3:0]        DIGIT_LIMIT  = 4'hA;
    localparam logic [3:0]        DIGIT_FIX    = 4'h6;
    localparam logic [HOUR_W:0]   HOUR_MAX     = 7'h23;
    localparam logic [MIN_W:0]    MIN_MAX      = 8'h59;
    localparam logic [HOUR_W-1:0] HOUR_DAY     = 6'h24;
    localparam logic [HOUR_W-1:0] HOUR_NOON    = 6'h12;
    localparam logic [HOUR_W-1:0] HOUR_TWENTY  = 6'h20;
    localparam logic [HOUR_W-1:0] HOUR_TW_ONE  = 6'h21;
    localparam logic [HOUR_W-1:0] HOUR_EIGHTN  = 6'h18;
    localparam logic [MIN_W-1:0]  MIN_SHOW_MAX = 7'h59;

    typedef struct packed {
        logic [MIN_W-1:0]  minutes;
        logic [HOUR_W-1:0] hours;
    } bcd_time_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ADJ
    } state_t;

endpackage

@@ rtl/bat_alu.sv @@
// shared bcd unit: time compare and hour/minute step with fix-up and wrap
module bat_alu
(
    input  bat_pkg::bcd_time_t opnd_a,
    input  bat_pkg::bcd_time_t opnd_b,
    input  logic               hour_step,
    input  logic               minute_step,
    output logic               equal,
    output bat_pkg::bcd_time_t adjusted
);
    import bat_pkg::*;

    logic [HOUR_W:0] hour_sum;
    logic [HOUR_W:0] hour_fix;
    logic [MIN_W:0]  min_sum;
    logic [MIN_W:0]  min_fix;

    assign equal = (opnd_a == opnd_b);

    always_comb
    begin
        hour_sum = {1'b0, opnd_a.hours} + {{HOUR_W{1'b0}}, hour_step};
        min_sum  = {1'b0, opnd_a.minutes} + {{MIN_W{1'b0}}, minute_step};

        // low digit past nine carries into the tens digit
        if (hour_sum[3:0] >= DIGIT_LIMIT)
            hour_fix = hour_sum + {{(HOUR_W-3){1'b0}}, DIGIT_FIX};
        else
            hour_fix = hour_sum;
        if (min_sum[3:0] >= DIGIT_LIMIT)
            min_fix = min_sum + {{(MIN_W-3){1'b0}}, DIGIT_FIX};
        else
            min_fix = min_sum;

        // wrap past the end of the day or hour
        if (hour_fix > HOUR_MAX)
            adjusted.hours = '0;
        else
            adjusted.hours = hour_fix[HOUR_W-1:0];
        if (min_fix > MIN_MAX)
            adjusted.minutes = '0;
        else
            adjusted.minutes = min_fix[MIN_W-1:0];
    end

endmodule

@@ rtl/bat_fmt.sv @@
// display formatter: 12-hour or 24-hour hours, minutes limited to bcd 59
module bat_fmt
(
    input  bat_pkg::bcd_time_t raw,
    input  logic               format_24_hour,
    output bat_pkg::bcd_time_t shown
);
    import bat_pkg::*;

    always_comb
    begin
        if (format_24_hour)
        begin
            if (raw.hours >= HOUR_DAY)
                shown.hours = '0;
            else
                shown.hours = raw.hours;
        end
        else
        begin
            if (raw.hours == '0)
                shown.hours = HOUR_NOON;
            else if (raw.hours == HOUR_TWENTY || raw.hours == HOUR_TW_ONE)
                shown.hours = raw.hours - HOUR_EIGHTN;
            else if (raw.hours > HOUR_NOON)
                shown.hours = raw.hours - HOUR_NOON;
            else
                shown.hours = raw.hours;
        end

        if (raw.minutes > MIN_SHOW_MAX)
            shown.minutes = '0;
        else
            shown.minutes = raw.minutes;
    end

endmodule

@@ rtl/bcd_alarm_table_and_time_format.sv @@
// top level: bcd alarm table with edge-detected alarm match and time formatter
//
// The block holds ALARM_SLOTS bcd alarm times and the last clock reading.
// Each input transaction carries an operation in s_tuser: 0 presents a new
// clock reading (alarms equal to it fire, unless the reading is unchanged),
// 1 steps one alarm by hour_step/minute_step and returns it, 2 and 3 step the
// given time without touching state. Every result but that of func 1 on an
// out-of-range slot (all zero) carries the raw 24-hour time and its display
// form under the format_24_hour register (cfg port, reset value 0). Timing:
// the core is one shared compare/adjust unit under a small sequencer that
// takes one alarm per cycle. An observe transaction steps through the alarms
// with a fire_mask bit, an adjust transaction through the adjust state, and
// then the sequencer returns to idle. Results land in an output register, so
// the next transaction is taken while a result waits on m_tready; the
// sequencer stalls only if a second result is ready before the first was
// taken. Only alarms 0 to 3 have a fire_mask bit.
module bcd_alarm_table_and_time_format
#(
    parameter int ALARM_SLOTS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [5:0] time_hours, [12:6] time_minutes, [14:13] slot,
    // [15] hour_step, [16] minute_step, [23:17] zero
    input  logic [23:0] s_tdata,
    // [1:0] func
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] fire_mask, [9:4] raw_hours, [16:10] raw_minutes,
    // [22:17] shown_hours, [29:23] shown_minutes, [31:30] zero
    output logic [31:0] m_tdata,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data
);
    import bat_pkg::*;

    localparam int IDX_W  = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
    // only the first four alarms can report a hit
    localparam int SCAN_N = (ALARM_SLOTS < MASK_W) ? ALARM_SLOTS : MASK_W;
    localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(SCAN_N - 1);

    // sequencer
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;

    // captured transaction
    logic [FUNC_W-1:0] func_reg;
    bcd_time_t         time_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              hs_reg;
    logic              ms_reg;

    // block state
    logic [MASK_W-1:0] mask_reg, mask_next;
    bcd_time_t         prev_reg;
    bcd_time_t         alarm_reg [ALARM_SLOTS];
    logic              fmt24_reg;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_data_reg;

    logic              in_accept;
    logic              out_free;
    logic              finishing;
    logic              out_load;
    logic              slot_ok;
    logic              moved;
    logic              alarm_we;
    logic [IDX_W-1:0]  alarm_idx;
    bcd_time_t         alarm_rd;
    bcd_time_t         alu_a;
    logic              alu_equal;
    bcd_time_t         alu_adj;
    logic [MASK_W-1:0] hit_bits;
    bcd_time_t         res_time;
    bcd_time_t         res_shown;
    logic [31:0]       res_data;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign slot_ok  = (32'(slot_reg) < ALARM_SLOTS);
    assign moved    = (time_reg != prev_reg);

    // scan walks the table, adjust reads the addressed slot
    assign alarm_idx = (state_reg == ST_SCAN) ? cnt_reg : IDX_W'(slot_reg);
    assign alarm_rd  = (32'(alarm_idx) < ALARM_SLOTS) ? alarm_reg[alarm_idx] : '0;

    // observe compares alarm against reading; alarm func steps the alarm,
    // the other funcs step the given time
    assign alu_a = (state_reg == ST_SCAN || func_reg == FUNC_ALARM) ? alarm_rd : time_reg;

    bat_alu u_alu
    (
        .opnd_a      (alu_a),
        .opnd_b      (time_reg),
        .hour_step   (hs_reg),
        .minute_step (ms_reg),
        .equal       (alu_equal),
        .adjusted    (alu_adj)
    );

    assign hit_bits = (state_reg == ST_SCAN && alu_equal && moved)
                      ? (MASK_W'(1) << cnt_reg) : '0;
    assign mask_next = mask_reg | hit_bits;

    assign finishing = (state_reg == ST_SCAN && cnt_reg == SCAN_LAST) || state_reg == ST_ADJ;
    assign out_load  = finishing && out_free;
    assign alarm_we  = state_reg == ST_ADJ && func_reg == FUNC_ALARM && slot_ok && out_free;

    assign res_time = (func_reg == FUNC_OBSERVE) ? time_reg : alu_adj;

    bat_fmt u_fmt
    (
        .raw            (res_time),
        .format_24_hour (fmt24_reg),
        .shown          (res_shown)
    );

    // alarm func on an out-of-range slot gives an all-zero result
    always_comb
    begin
        if (func_reg == FUNC_ALARM && !slot_ok)
            res_data = '0;
        else if (func_reg == FUNC_OBSERVE)
            res_data = {2'b00, res_shown.minutes, res_shown.hours,
                        res_time.minutes, res_time.hours, mask_next};
        else
            res_data = {2'b00, res_shown.minutes, res_shown.hours,
                        res_time.minutes, res_time.hours, {MASK_W{1'b0}}};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == FUNC_OBSERVE)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_ADJ;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == SCAN_LAST && out_free)
                    state_next = ST_IDLE;
            end
            ST_ADJ:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready = 1'b0;
        cnt_next = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cnt_next = '0;
            end
            ST_SCAN:
            begin
                // hold on the last alarm until the output register frees up
                if (cnt_reg != SCAN_LAST)
                    cnt_next = cnt_reg + IDX_W'(1);
            end
            ST_ADJ:
            begin
                cnt_next = '0;
            end
            default:
            begin
                s_tready = 1'b0;
                cnt_next = '0;
            end
        endcase
    end

    // output register handshake
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
            prev_reg      <= '0;
            fmt24_reg     <= 1'b0;
            for (int i = 0; i < ALARM_SLOTS; i++)
                alarm_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;

            if (in_accept)
                mask_reg <= '0;
            else if (state_reg == ST_SCAN)
                mask_reg <= mask_next;

            // reading becomes the previous time once the scan is done
            if (state_reg == ST_SCAN && out_load)
                prev_reg <= time_reg;

            if (cfg_valid && cfg_ready)
                fmt24_reg <= cfg_data[0];

            for (int i = 0; i < ALARM_SLOTS; i++)
            begin
                if (alarm_we && alarm_idx == IDX_W'(i))
                    alarm_reg[i] <= alu_adj;
            end
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg         <= s_tuser;
            time_reg.hours   <= s_tdata[5:0];
            time_reg.minutes <= s_tdata[12:6];
            slot_reg         <= s_tdata[14:13];
            hs_reg           <= s_tdata[15];
            ms_reg           <= s_tdata[16];
        end
        if (out_load)
            out_data_reg <= res_data;
    end

endmodule
